// File: rtl/utf8_canonical_text_checker_macros.svh
// assertion macros for the utf8 canonical text checker
// expects clk and rst in the scope of each use; no other dependencies
`ifndef UTF8_CANONICAL_TEXT_CHECKER_MACROS_SVH
`define UTF8_CANONICAL_TEXT_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF
`define UCTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UCTC_ASSERT_IMP(lbl, pre, post, msg) \
  `UCTC_ASSERT(lbl, (pre) |-> (post), msg)
`else
`define UCTC_ASSERT(lbl, prop, msg)
`define UCTC_ASSERT_IMP(lbl, pre, post, msg)
`endif

`endif

// File: rtl/uctc_pkg.sv
// shared types, fault codes and helper functions for the utf8 text checker
// no dependencies
`timescale 1ns / 1ps

package uctc_pkg;

  localparam int CountBits = 16;
  localparam int CpBits    = 21;

  typedef enum logic [3:0] {
    FK_NONE        = 4'd0,
    FK_EMPTY       = 4'd1,
    FK_BAD_LEAD    = 4'd2,
    FK_BAD_CONT    = 4'd3,
    FK_TRUNC       = 4'd4,
    FK_OVERLONG    = 4'd5,
    FK_SURROGATE   = 4'd6,
    FK_ABOVE_MAX   = 4'd7,
    FK_LEAD_SPACE  = 4'd8,
    FK_TRAIL_SPACE = 4'd9,
    FK_NUL         = 4'd10
  } fault_kind_t;

  // one input request
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_text;
  } item_t;

  // one result request
  typedef struct packed {
    logic                 utf8_ok;
    logic                 canonical_ok;
    fault_kind_t          fault_kind;
    logic [CpBits-1:0]    first_code_point;
    logic [CpBits-1:0]    last_code_point;
    logic [CountBits-1:0] byte_count;
  } result_t;

  // unicode whitespace set
  function automatic logic is_white(input logic [CpBits-1:0] v);
    is_white = (v >= 21'h09 && v <= 21'h0d) || v == 21'h20 || v == 21'h85 ||
               v == 21'ha0 || v == 21'h1680 || (v >= 21'h2000 && v <= 21'h200a) ||
               v == 21'h2028 || v == 21'h2029 || v == 21'h202f || v == 21'h205f ||
               v == 21'h3000;
  endfunction

  // first fault wins
  function automatic fault_kind_t keep_first(input fault_kind_t cur, input fault_kind_t kind);
    keep_first = (cur == FK_NONE) ? kind : cur;
  endfunction

endpackage

// File: rtl/uctc_in_stage.sv
// input register: holds one byte request in front of the decoder
// depends on uctc_pkg
`timescale 1ns / 1ps

module uctc_in_stage import uctc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  held_valid,
  output item_t held_item,
  input  logic  pop
);

  logic  valid;
  item_t item;

  assign in_ready   = !valid || pop;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// File: rtl/uctc_core.sv
// decoder state and single-pass step logic: one byte per cycle unless an end request waits on a full result register
// depends on uctc_pkg
`timescale 1ns / 1ps

module uctc_core import uctc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    res_ready,
  output logic    pop,
  output logic    res_valid,
  output result_t res
);

  localparam logic [CountBits-1:0] CountMax = '1;

  logic [1:0]           pend,  pend_next;
  logic [2:0]           width, width_next;
  logic [CpBits-1:0]    part,  part_next;
  fault_kind_t          fault, fault_next;
  logic                 seen,  seen_next;
  logic [CpBits-1:0]    first, first_next;
  logic [CpBits-1:0]    last,  last_next;
  logic [CountBits-1:0] cnt,   cnt_next;
  logic                 bad,   bad_next;

  logic              cp_done;
  logic [CpBits-1:0] cp_val;
  logic [CpBits-1:0] shifted;
  logic [1:0]        pend_dec;
  logic [7:0]        b;

  // an end request needs room in the result register
  assign pop       = item_valid && (!item.end_of_text || res_ready);
  assign res_valid = pop && item.end_of_text;
  assign b         = item.data_byte;
  assign shifted   = {part[CpBits-7:0], b[5:0]};
  assign pend_dec  = pend - 2'd1;

  always_comb begin
    pend_next  = pend;
    width_next = width;
    part_next  = part;
    fault_next = fault;
    seen_next  = seen;
    first_next = first;
    last_next  = last;
    cnt_next   = cnt;
    bad_next   = bad;
    cp_done    = 1'b0;
    cp_val     = '0;
    res        = '0;

    if (pop && item.has_byte) begin
      if (cnt != CountMax) begin
        cnt_next = cnt + 1'b1;
      end
      if (!bad) begin
        if (pend == 2'd0) begin
          priority if (b <= 8'h7f) begin
            if (b == 8'h00) begin
              fault_next = keep_first(fault_next, FK_NUL);
            end
            cp_done = 1'b1;
            cp_val  = {{(CpBits-8){1'b0}}, b};
          end else if (b >= 8'hc2 && b <= 8'hdf) begin
            width_next = 3'd2;
            pend_next  = 2'd1;
            part_next  = {{(CpBits-5){1'b0}}, b[4:0]};
          end else if (b >= 8'he0 && b <= 8'hef) begin
            width_next = 3'd3;
            pend_next  = 2'd2;
            part_next  = {{(CpBits-4){1'b0}}, b[3:0]};
          end else if (b >= 8'hf0 && b <= 8'hf4) begin
            width_next = 3'd4;
            pend_next  = 2'd3;
            part_next  = {{(CpBits-3){1'b0}}, b[2:0]};
          end else begin
            bad_next   = 1'b1;
            pend_next  = 2'd0;
            fault_next = keep_first(fault_next, FK_BAD_LEAD);
          end
        end else if (b[7:6] != 2'b10) begin
          bad_next   = 1'b1;
          pend_next  = 2'd0;
          fault_next = keep_first(fault_next, FK_BAD_CONT);
        end else begin
          part_next = shifted;
          pend_next = pend_dec;
          if (pend_dec == 2'd0) begin
            // range checks once the sequence is complete
            priority if ((width == 3'd3 && shifted < 21'h800) ||
                         (width == 3'd4 && shifted < 21'h10000)) begin
              bad_next   = 1'b1;
              fault_next = keep_first(fault_next, FK_OVERLONG);
            end else if (shifted >= 21'hd800 && shifted <= 21'hdfff) begin
              bad_next   = 1'b1;
              fault_next = keep_first(fault_next, FK_SURROGATE);
            end else if (shifted > 21'h10ffff) begin
              bad_next   = 1'b1;
              fault_next = keep_first(fault_next, FK_ABOVE_MAX);
            end else begin
              cp_done = 1'b1;
              cp_val  = shifted;
            end
          end
        end
      end
    end

    if (cp_done) begin
      if (!seen) begin
        seen_next  = 1'b1;
        first_next = cp_val;
        if (is_white(cp_val)) begin
          fault_next = keep_first(fault_next, FK_LEAD_SPACE);
        end
      end
      last_next = cp_val;
    end

    if (res_valid) begin
      if (!bad_next && pend_next != 2'd0) begin
        bad_next   = 1'b1;
        fault_next = keep_first(fault_next, FK_TRUNC);
      end
      if (cnt_next == '0) begin
        fault_next = keep_first(fault_next, FK_EMPTY);
      end
      if (!bad_next && seen_next && is_white(last_next)) begin
        fault_next = keep_first(fault_next, FK_TRAIL_SPACE);
      end
      res.utf8_ok          = !bad_next;
      res.canonical_ok     = (fault_next == FK_NONE);
      res.fault_kind       = fault_next;
      res.first_code_point = first_next;
      res.last_code_point  = last_next;
      res.byte_count       = cnt_next;
      // back to the start for the next text
      pend_next  = '0;
      width_next = '0;
      part_next  = '0;
      fault_next = FK_NONE;
      seen_next  = 1'b0;
      first_next = '0;
      last_next  = '0;
      cnt_next   = '0;
      bad_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      width <= '0;
      part  <= '0;
      fault <= FK_NONE;
      seen  <= 1'b0;
      first <= '0;
      last  <= '0;
      cnt   <= '0;
      bad   <= 1'b0;
    end else begin
      pend  <= pend_next;
      width <= width_next;
      part  <= part_next;
      fault <= fault_next;
      seen  <= seen_next;
      first <= first_next;
      last  <= last_next;
      cnt   <= cnt_next;
      bad   <= bad_next;
    end
  end

endmodule

// File: rtl/uctc_out_stage.sv
// result register: holds one finished result until the sink takes it
// depends on uctc_pkg
`timescale 1ns / 1ps

module uctc_out_stage import uctc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid;
  result_t held;

  assign room      = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_res;
    end
  end

endmodule

// File: rtl/utf8_canonical_text_checker.sv
// top level of the strict utf-8 / canonical text checker
// depends on uctc_pkg, uctc_in_stage, uctc_core, uctc_out_stage and the macros header
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: data_byte, tuser: has_byte, tlast: end_of_text
//   m_*      out  m_tvalid/m_tready  tdata: one result per text
//
// one byte request per cycle while no end request waits on a full result register; the input register feeds single-pass
// decode logic that updates the decoder state in the same cycle
// a result is loaded into the result register when its end request leaves the decoder
// rst is synchronous, active high, and clears both stages and the decoder state
// only an end request waits on a full result register; requests behind it back up
`timescale 1ns / 1ps
`include "utf8_canonical_text_checker_macros.svh"

module utf8_canonical_text_checker import uctc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] utf8_ok, [1] canonical_ok, [5:2] fault_kind, [26:6] first_code_point,
  // [47:27] last_code_point, [63:48] byte_count
  output logic [63:0] m_tdata
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    pop;
  logic    res_valid;
  result_t res;
  logic    room;
  result_t out_res;

  assign in_item.has_byte    = s_tuser;
  assign in_item.data_byte   = s_tdata;
  assign in_item.end_of_text = s_tlast;

  uctc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .pop        (pop)
  );

  uctc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (held_valid),
    .item       (held_item),
    .res_ready  (room),
    .pop        (pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  uctc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // pack fields from the lowest bit up
  assign m_tdata = {out_res.byte_count, out_res.last_code_point, out_res.first_code_point,
                    out_res.fault_kind, out_res.canonical_ok, out_res.utf8_ok};

  // input side only backs up behind a waiting result
  `UCTC_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled without a waiting result")
  // canonical implies well-formed
  `UCTC_ASSERT_IMP(a_canon_utf8, m_tvalid && out_res.canonical_ok, out_res.utf8_ok, "canonical_ok without utf8_ok")
  // canonical flag agrees with the fault code
  `UCTC_ASSERT_IMP(a_canon_fault, m_tvalid, out_res.canonical_ok == (out_res.fault_kind == FK_NONE), "canonical_ok disagrees with fault_kind")
  // a malformed text always carries a fault code
  `UCTC_ASSERT_IMP(a_bad_fault, m_tvalid && !out_res.utf8_ok, out_res.fault_kind != FK_NONE, "utf8 fault without fault code")
  // an empty text can only report empty
  `UCTC_ASSERT_IMP(a_empty, m_tvalid && out_res.byte_count == '0, out_res.fault_kind == FK_EMPTY, "empty text with other fault")

endmodule

// File: bench/tb_utf8_canonical_text_checker.sv
// self-checking bench for utf8_canonical_text_checker: streams byte requests with random
// gaps on both sides and checks every verdict against a cycle-free decoder written here
// depends on uctc_pkg and the checker rtl
`timescale 1ns / 1ps

module tb_utf8_canonical_text_checker;
  import uctc_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int RandomItems = 2000;

  typedef struct {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_text;
    logic       drain_first;
  } text_request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  text_request_t pending_requests[$];
  result_t       expected_verdicts[$];
  logic [7:0]    text_bytes[$];

  // decoder state mirrored from the block
  logic [1:0]  cont_left = '0;
  logic [2:0]  seq_len = '0;
  logic [20:0] accum = '0;
  fault_kind_t first_fault = FK_NONE;
  logic        got_first = 1'b0;
  logic [20:0] head_cp = '0;
  logic [20:0] tail_cp = '0;
  logic [15:0] nbytes = '0;
  logic        broken = 1'b0;

  logic in_fire = 1'b0;
  int   in_count = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   tx_gap = 0;
  int   tx_cycle = 0;
  logic tx_calm = 1'b0;
  int   rx_gap = 0;
  int   rx_cycle = 0;
  logic rx_calm = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  utf8_canonical_text_checker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- decoder

  function automatic logic spacing_char(input logic [20:0] v);
    case (v)
      21'h09, 21'h0a, 21'h0b, 21'h0c, 21'h0d, 21'h20, 21'h85, 21'ha0, 21'h1680,
      21'h2028, 21'h2029, 21'h202f, 21'h205f, 21'h3000: spacing_char = 1'b1;
      default: spacing_char = (v >= 21'h2000 && v <= 21'h200a);
    endcase
  endfunction

  function automatic void clear_decoder();
    cont_left = '0;
    seq_len = '0;
    accum = '0;
    first_fault = FK_NONE;
    got_first = 1'b0;
    head_cp = '0;
    tail_cp = '0;
    nbytes = '0;
    broken = 1'b0;
  endfunction

  function automatic void note_fault(input fault_kind_t kind);
    if (first_fault == FK_NONE) first_fault = kind;
  endfunction

  function automatic void encoding_fault(input fault_kind_t kind);
    broken = 1'b1;
    cont_left = '0;
    note_fault(kind);
  endfunction

  function automatic void accept_point(input logic [20:0] cp);
    if (!got_first) begin
      got_first = 1'b1;
      head_cp = cp;
      if (spacing_char(cp)) note_fault(FK_LEAD_SPACE);
    end
    tail_cp = cp;
  endfunction

  function automatic void take_text_byte(input logic [7:0] b);
    if (nbytes != 16'hffff) nbytes++;
    if (broken) return;
    if (cont_left == 0) begin
      if (b < 8'h80) begin
        if (b == 8'h00) note_fault(FK_NUL);
        accept_point({13'd0, b});
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        seq_len = 3'd2;
        cont_left = 2'd1;
        accum = {16'd0, b[4:0]};
      end else if (b >= 8'he0 && b <= 8'hef) begin
        seq_len = 3'd3;
        cont_left = 2'd2;
        accum = {17'd0, b[3:0]};
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        seq_len = 3'd4;
        cont_left = 2'd3;
        accum = {18'd0, b[2:0]};
      end else begin
        encoding_fault(FK_BAD_LEAD);
      end
      return;
    end
    if (b[7:6] != 2'b10) begin
      encoding_fault(FK_BAD_CONT);
      return;
    end
    accum = {accum[14:0], b[5:0]};
    cont_left--;
    if (cont_left != 0) return;
    // range checks once the sequence is complete, overlong first
    if ((seq_len == 3'd3 && accum < 21'h800) || (seq_len == 3'd4 && accum < 21'h10000))
      encoding_fault(FK_OVERLONG);
    else if (accum >= 21'hd800 && accum <= 21'hdfff)
      encoding_fault(FK_SURROGATE);
    else if (accum > 21'h10ffff)
      encoding_fault(FK_ABOVE_MAX);
    else
      accept_point(accum);
  endfunction

  function automatic void decode_request(input logic has, input logic [7:0] b, input logic last);
    result_t v;
    if (has) take_text_byte(b);
    if (!last) return;
    if (!broken && cont_left != 0) encoding_fault(FK_TRUNC);
    if (nbytes == 0) note_fault(FK_EMPTY);
    if (!broken && got_first && spacing_char(tail_cp)) note_fault(FK_TRAIL_SPACE);
    v.utf8_ok = !broken;
    v.canonical_ok = (first_fault == FK_NONE);
    v.fault_kind = first_fault;
    v.first_code_point = head_cp;
    v.last_code_point = tail_cp;
    v.byte_count = nbytes;
    expected_verdicts.insert(expected_verdicts.size(), v);
    clear_decoder();
  endfunction

  // ---------------------------------------------------------------- text generation

  function automatic void add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] lead_for(input int w);
    if (w == 2) return 8'($urandom_range('hc2, 'hdf));
    if (w == 3) return 8'($urandom_range('he0, 'hef));
    return 8'($urandom_range('hf0, 'hf4));
  endfunction

  function automatic logic [20:0] blank_point();
    case ($urandom_range(0, 7))
      0: return 21'($urandom_range('h09, 'h0d));
      1: return 21'h20;
      2: return 21'h85;
      3: return 21'ha0;
      4: return 21'h1680;
      5: return 21'($urandom_range('h2000, 'h200a));
      6: begin
        case ($urandom_range(0, 3))
          0: return 21'h2028;
          1: return 21'h2029;
          2: return 21'h202f;
          default: return 21'h205f;
        endcase
      end
      default: return 21'h3000;
    endcase
  endfunction

  function automatic logic [20:0] random_point();
    logic [20:0] cp;
    case ($urandom_range(0, 5))
      0, 1: return 21'($urandom_range('h01, 'h7f));
      2: return 21'($urandom_range('h80, 'h7ff));
      3: begin
        // skip the surrogate block
        cp = 21'($urandom_range('h800, 'hf7ff));
        if (cp >= 21'hd800) cp = cp + 21'h800;
        return cp;
      end
      4: return 21'($urandom_range('h10000, 'h10ffff));
      default: return blank_point();
    endcase
  endfunction

  task automatic push_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endtask

  // malformed sequence; cut is set when the text has to end right after it
  task automatic push_fault(output logic cut);
    int w;
    int top;
    cut = 1'b0;
    case ($urandom_range(0, 6))
      0: begin
        if ($urandom_range(0, 1)) add_byte(8'($urandom_range('h80, 'hc1)));
        else add_byte(8'($urandom_range('hf5, 'hff)));
      end
      1: begin
        w = $urandom_range(2, 4);
        add_byte(lead_for(w));
        if (w > 2 && $urandom_range(0, 1)) add_byte(cont_byte());
        top = $urandom_range(0, 2);
        if (top == 2) top = 3;
        add_byte({2'(top), 6'($urandom)});
      end
      2: begin
        if ($urandom_range(0, 1)) begin
          add_byte(8'he0);
          add_byte({3'b100, 5'($urandom)});
        end else begin
          add_byte(8'hf0);
          add_byte({4'b1000, 4'($urandom)});
          add_byte(cont_byte());
        end
        add_byte(cont_byte());
      end
      3: begin
        add_byte(8'hed);
        add_byte({3'b101, 5'($urandom)});
        add_byte(cont_byte());
      end
      4: begin
        add_byte(8'hf4);
        add_byte(8'($urandom_range('h90, 'hbf)));
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      5: add_byte(8'h00);
      default: begin
        w = $urandom_range(2, 4);
        add_byte(lead_for(w));
        repeat ($urandom_range(0, w - 2)) add_byte(cont_byte());
        cut = 1'b1;
      end
    endcase
  endtask

  // turn the byte buffer into requests; an empty text always gets a closing request
  task automatic emit_text(input logic sep_end, input logic drain);
    text_request_t r;
    int last;
    last = text_bytes.size() - 1;
    for (int i = 0; i <= last; i++) begin
      r = '{1'b1, text_bytes[i], (i == last) && !sep_end, drain && (i == 0)};
      pending_requests.insert(pending_requests.size(), r);
      if ($urandom_range(0, 19) == 0) begin
        r = '{1'b0, 8'($urandom), 1'b0, 1'b0};
        pending_requests.insert(pending_requests.size(), r);
      end
    end
    if (sep_end || last < 0) begin
      r = '{1'b0, 8'($urandom), 1'b1, drain && (last < 0)};
      pending_requests.insert(pending_requests.size(), r);
    end
    text_bytes.delete();
  endtask

  function automatic int pick_gap(input logic calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // ---------------------------------------------------------------- stimulus and end

  initial begin
    text_request_t idle_req;
    int   random_items;
    int   n;
    int   shape;
    logic cut;
    logic drain;

    // directed texts
    emit_text(1'b1, 1'b0);                                        // empty
    text_bytes = {8'he0, 8'h80, 8'h80};              emit_text(1'b0, 1'b0);  // overlong
    text_bytes = {8'hed, 8'ha0, 8'h80};              emit_text(1'b0, 1'b0);  // surrogate
    text_bytes = {8'hf4, 8'h90, 8'h80, 8'h80};       emit_text(1'b0, 1'b0);  // above max
    text_bytes = {8'hff};                            emit_text(1'b0, 1'b0);  // bad lead
    text_bytes = {8'hc2, 8'h00};                     emit_text(1'b0, 1'b0);  // nul in sequence
    text_bytes = {8'he2, 8'h82};                     emit_text(1'b1, 1'b0);  // truncated
    text_bytes = {8'h00};                            emit_text(1'b0, 1'b0);  // nul
    idle_req = '{1'b0, 8'h5a, 1'b0, 1'b0};
    pending_requests.insert(pending_requests.size(), idle_req);   // neither byte nor end
    text_bytes = {8'h20, 8'h41};                     emit_text(1'b0, 1'b0);  // leading space
    text_bytes = {8'h41, 8'he3, 8'h80, 8'h80};       emit_text(1'b0, 1'b0);  // trailing U+3000

    // random texts, mostly well-formed with faults mixed in
    random_items = 0;
    drain = 1'b1;
    while (random_items < RandomItems) begin
      cut = 1'b0;
      shape = $urandom_range(0, 99);
      if (shape >= 5 && shape < 12) begin
        repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
      end else if (shape >= 12) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n && !cut; k++) begin
          if ($urandom_range(0, 99) < 8) push_fault(cut);
          else push_point(random_point());
        end
      end
      random_items += text_bytes.size() + 1;
      // the first random text waits for a drained pipe
      emit_text($urandom_range(0, 3) == 0, drain);
      drain = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- sender

  always @(negedge clk) begin
    text_request_t nxt;
    if (!rst) begin
      tx_cycle++;
      if (tx_cycle % 200 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (!s_tvalid || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() == 0 ||
                     (pending_requests[0].drain_first && expected_verdicts.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else begin
          nxt = pending_requests.pop_front();
          s_tdata <= nxt.data_byte;
          s_tuser <= nxt.has_byte;
          s_tlast <= nxt.end_of_text;
          s_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_calm);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (!rst) begin
      rx_cycle++;
      if (rx_cycle % 150 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      // one long hold-off so the result register fills and the input stalls
      if (!hold_done && in_count >= 600) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_gap = pick_gap(rx_calm);
      end
    end
  end

  // ---------------------------------------------------------------- prediction and check

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    in_fire = 1'b0;
    if (rst) begin
      clear_decoder();
    end else begin
      in_fire = s_tvalid && s_tready;
      if (in_fire) begin
        in_count++;
        decode_request(s_tuser, s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no text pending: m_tdata 0x%0h", m_tdata);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("utf8_ok", want.utf8_ok, m_tdata[0]);
          check_field("canonical_ok", want.canonical_ok, m_tdata[1]);
          check_field("fault_kind", want.fault_kind, m_tdata[5:2]);
          check_field("first_code_point", want.first_code_point, m_tdata[26:6]);
          check_field("last_code_point", want.last_code_point, m_tdata[47:27]);
          check_field("byte_count", want.byte_count, m_tdata[63:48]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/uctc_pkg.sv
rtl/uctc_in_stage.sv
rtl/uctc_core.sv
rtl/uctc_out_stage.sv
rtl/utf8_canonical_text_checker.sv
bench/tb_utf8_canonical_text_checker.sv
